// File: rtl/core/disk_request_sequencer_top_macros.svh
// assertion macros for the disk request sequencer
`ifndef DISK_REQUEST_SEQUENCER_TOP_MACROS_SVH
`define DISK_REQUEST_SEQUENCER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("disk request sequencer check failed");

// antecedent implies consequent in the next cycle
`define DRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("disk request sequencer check failed");

`endif

// File: rtl/core/drs_pkg.sv
// shared types and constants of the disk request sequencer
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;

   localparam logic [1:0] OP_SUBMIT = 2'd0;
   localparam logic [1:0] OP_IRQ    = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;

   localparam logic [1:0] KIND_RESET = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_XFER  = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] CMD_READ    = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_RESTORE = 2'd2;
   localparam logic [1:0] CMD_SPECIFY = 2'd3;

   localparam logic [1:0] CSR_SPT    = 2'd0;
   localparam logic [1:0] CSR_HEADS  = 2'd1;
   localparam logic [1:0] CSR_CYLS   = 2'd2;
   localparam logic [1:0] CSR_DRIVES = 2'd3;

   localparam logic [7:0] ST_MASK = 8'hF1;
   localparam logic [7:0] ST_GOOD = 8'h50;

   localparam logic [2:0] MAX_RETRIES = 3'd7;
   localparam logic [2:0] RESET_LIMIT = 3'(MAX_RETRIES / 2);
   localparam logic [1:0] DRIVES_MAX  = 2'd2;
   localparam logic [3:0] MINOR_STRIDE = 4'd5;
   localparam logic [4:0] HEADS_MAX   = 5'd16;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_READ  = 3'd1,
      EV_WRITE = 3'd2,
      EV_RECAL = 3'd3,
      EV_DRQ   = 3'd4
   } event_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_CHECK,
      S_DIV_SEC,
      S_DIV_HEAD,
      S_OUT_RESET,
      S_OUT_SPECIFY,
      S_OUT_RESTORE,
      S_OUT_COMMAND,
      S_OUT_XFER,
      S_OUT_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_a;
      logic       mul_b;
      logic       div_sec;
      logic       div_head;
      logic       sector_inc;
      logic       left_dec;
      logic       emit;
      logic [1:0] emit_kind;
      logic [1:0] emit_cmd;
      logic       emit_success;
      logic       emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic bounds_ok;
      logic left_is_one;
      logic div_busy;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/core/drs_datapath.sv
// datapath: geometry registers, request registers, capacity check, divider, result register
`timescale 1ns / 1ps
`default_nettype none
module drs_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic [3:0]           minor_device,
   input  wire logic [31:0]          start_sector,
   input  wire logic [7:0]           sector_total,
   input  wire drs_pkg::ctrl_cmd_type cmd,
   output drs_pkg::dp_status_type    sts,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_kind,
   output logic [1:0]                rsp_command,
   output logic                      rsp_drive,
   output logic [7:0]                rsp_sector_number,
   output logic [3:0]                rsp_head,
   output logic [15:0]               rsp_cylinder,
   output logic [7:0]                rsp_count_field,
   output logic                      rsp_success,
   output logic                      rsp_last
);

   logic [7:0]  spt_ff;
   logic [4:0]  heads_ff;
   logic [15:0] cyls_ff;
   logic [1:0]  drives_ff;
   logic [3:0]  minor_ff;
   logic [31:0] sector_ff;
   logic [7:0]  left_ff;
   logic [12:0] prod_ff, prod_in;
   logic [28:0] cap_ff, cap_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [7:0]  secn_ff, secn_in;
   logic [4:0]  heads_eff;
   logic [1:0]  drives_eff;
   logic        drive_sel;
   logic [8:0]  trial;
   logic        trial_ge;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  ocmd_ff, ocmd_in;
   logic        drv_ff, drv_in;
   logic [7:0]  osec_ff, osec_in;
   logic [3:0]  ohead_ff, ohead_in;
   logic [15:0] ocyl_ff, ocyl_in;
   logic [7:0]  ocnt_ff, ocnt_in;
   logic        ok_ff, ok_in;
   logic        last_ff, last_in;

   always_comb begin
      heads_eff  = (heads_ff > drs_pkg::HEADS_MAX) ? drs_pkg::HEADS_MAX : heads_ff;
      drives_eff = (drives_ff > drs_pkg::DRIVES_MAX) ? drs_pkg::DRIVES_MAX : drives_ff;
      drive_sel  = (minor_ff == drs_pkg::MINOR_STRIDE);
   end

   // configuration and request registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff    <= 8'd17;
         heads_ff  <= 5'd4;
         cyls_ff   <= 16'd615;
         drives_ff <= 2'd1;
      end else if (csr_we) begin
         case (csr_index)
            drs_pkg::CSR_SPT:    spt_ff    <= csr_wdata[7:0];
            drs_pkg::CSR_HEADS:  heads_ff  <= csr_wdata[4:0];
            drs_pkg::CSR_CYLS:   cyls_ff   <= csr_wdata;
            drs_pkg::CSR_DRIVES: drives_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minor_ff  <= '0;
         sector_ff <= '0;
         left_ff   <= '0;
      end else begin
         if (cmd.load) begin
            minor_ff  <= minor_device;
            sector_ff <= start_sector;
            left_ff   <= sector_total;
         end else begin
            if (cmd.sector_inc) sector_ff <= sector_ff + 32'd1;
            if (cmd.left_dec) left_ff <= left_ff - 8'd1;
         end
      end
   end

   // capacity = spt * heads * cylinders, spt * heads on mul_a, then times cylinders on mul_b
   always_comb begin
      prod_in = cmd.mul_a ? (13'(spt_ff) * 13'(heads_eff)) : prod_ff;
      cap_in  = cmd.mul_b ? (29'(prod_ff) * 29'(cyls_ff)) : cap_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cap_ff  <= cap_in;
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      trial    = {rem_ff, dvd_ff[31]};
      trial_ge = (trial >= {1'b0, dsr_ff});
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      secn_in  = secn_ff;
      if (cmd.div_sec) begin
         dvd_in  = sector_ff;
         rem_in  = '0;
         dsr_in  = spt_ff;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (cmd.div_head) begin
         secn_in = rem_ff + 8'd1;
         dvd_in  = dvd_ff;
         rem_in  = '0;
         dsr_in  = {3'b000, heads_eff};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial_ge ? 8'(trial - {1'b0, dsr_ff}) : trial[7:0];
         dvd_in = {dvd_ff[30:0], trial_ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      secn_ff <= secn_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   always_comb begin
      sts.out_free    = !valid_ff || rsp_ready;
      sts.bounds_ok   = (((minor_ff == 4'd0) && (drives_eff != 2'd0)) ||
                         (drive_sel && (drives_eff == drs_pkg::DRIVES_MAX))) &&
                        (({1'b0, sector_ff} + 33'd2) <= {4'b0000, cap_ff});
      sts.left_is_one = (left_ff == 8'd1);
      sts.div_busy    = busy_ff;
   end

   // result formatting, unused fields stay zero
   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      ocmd_in  = ocmd_ff;
      drv_in   = drv_ff;
      osec_in  = osec_ff;
      ohead_in = ohead_ff;
      ocyl_in  = ocyl_ff;
      ocnt_in  = ocnt_ff;
      ok_in    = ok_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.emit_kind;
         last_in  = cmd.emit_last;
         ocmd_in  = '0;
         drv_in   = 1'b0;
         osec_in  = '0;
         ohead_in = '0;
         ocyl_in  = '0;
         ocnt_in  = '0;
         ok_in    = 1'b0;
         case (cmd.emit_kind)
            drs_pkg::KIND_CMD: begin
               ocmd_in = cmd.emit_cmd;
               drv_in  = drive_sel;
               case (cmd.emit_cmd)
                  drs_pkg::CMD_SPECIFY: begin
                     osec_in  = spt_ff;
                     ohead_in = 4'(heads_eff - 5'd1);
                     ocyl_in  = cyls_ff;
                     ocnt_in  = spt_ff;
                  end
                  drs_pkg::CMD_RESTORE: begin
                     ocnt_in = spt_ff;
                  end
                  default: begin
                     osec_in  = secn_ff;
                     ohead_in = rem_ff[3:0];
                     ocyl_in  = dvd_ff[15:0];
                     ocnt_in  = left_ff;
                  end
               endcase
            end
            drs_pkg::KIND_DONE: ok_in = cmd.emit_success;
            default: ;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      kind_ff  <= kind_in;
      ocmd_ff  <= ocmd_in;
      drv_ff   <= drv_in;
      osec_ff  <= osec_in;
      ohead_ff <= ohead_in;
      ocyl_ff  <= ocyl_in;
      ocnt_ff  <= ocnt_in;
      ok_ff    <= ok_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_command       = ocmd_ff;
   assign rsp_drive         = drv_ff;
   assign rsp_sector_number = osec_ff;
   assign rsp_head          = ohead_ff;
   assign rsp_cylinder      = ocyl_ff;
   assign rsp_count_field   = ocnt_ff;
   assign rsp_success       = ok_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

// File: rtl/core/drs_ctrl.sv
// controller: request state, retry bookkeeping and sequencing of the datapath
`timescale 1ns / 1ps
`default_nettype none
module drs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            op,
   input  wire logic                  is_write,
   input  wire logic [7:0]            status_byte,
   input  wire logic                  data_ready,
   input  wire drs_pkg::dp_status_type sts,
   output drs_pkg::ctrl_cmd_type      cmd
);

   drs_pkg::state_type state_ff, state_in;
   drs_pkg::event_type await_ff, await_in;
   logic       active_ff, active_in;
   logic       write_ff, write_in;
   logic [2:0] err_ff, err_in;
   logic       rst_pend_ff, rst_pend_in;
   logic       recal_ff, recal_in;
   logic       done_next_ff, done_next_in;
   logic       ok_ff, ok_in;
   logic       good;
   logic       bad;
   logic       take;
   logic [2:0] err_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drs_pkg::S_IDLE;
         await_ff     <= drs_pkg::EV_NONE;
         active_ff    <= 1'b0;
         write_ff     <= 1'b0;
         err_ff       <= '0;
         rst_pend_ff  <= 1'b0;
         recal_ff     <= 1'b0;
         done_next_ff <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         await_ff     <= await_in;
         active_ff    <= active_in;
         write_ff     <= write_in;
         err_ff       <= err_in;
         rst_pend_ff  <= rst_pend_in;
         recal_ff     <= recal_in;
         done_next_ff <= done_next_in;
         ok_ff        <= ok_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      await_in     = await_ff;
      active_in    = active_ff;
      write_in     = write_ff;
      err_in       = err_ff;
      rst_pend_in  = rst_pend_ff;
      recal_in     = recal_ff;
      done_next_in = done_next_ff;
      ok_in        = ok_ff;
      cmd          = '0;
      req_ready    = (state_ff == drs_pkg::S_IDLE);
      take         = req_valid && req_ready;
      good         = ((status_byte & drs_pkg::ST_MASK) == drs_pkg::ST_GOOD);
      err_inc      = err_ff + 3'd1;
      bad          = 1'b0;

      case (state_ff)
         drs_pkg::S_IDLE: begin
            if (take) begin
               case (op)
                  drs_pkg::OP_SUBMIT: begin
                     if (!active_ff) begin
                        active_in = 1'b1;
                        write_in  = is_write;
                        err_in    = '0;
                        cmd.load  = 1'b1;
                        await_in  = drs_pkg::EV_NONE;
                        state_in  = drs_pkg::S_MUL_A;
                     end
                  end
                  drs_pkg::OP_POLL: begin
                     if (await_ff == drs_pkg::EV_DRQ) begin
                        if (data_ready) begin
                           await_in     = drs_pkg::EV_WRITE;
                           done_next_in = 1'b0;
                           state_in     = drs_pkg::S_OUT_XFER;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                  end
                  drs_pkg::OP_IRQ: begin
                     case (await_ff)
                        drs_pkg::EV_READ: begin
                           if (!good) begin
                              bad = 1'b1;
                           end else begin
                              err_in         = '0;
                              cmd.sector_inc = 1'b1;
                              cmd.left_dec   = 1'b1;
                              state_in       = drs_pkg::S_OUT_XFER;
                              done_next_in   = sts.left_is_one;
                              if (sts.left_is_one) begin
                                 ok_in     = 1'b1;
                                 active_in = 1'b0;
                                 await_in  = drs_pkg::EV_NONE;
                              end
                           end
                        end
                        drs_pkg::EV_WRITE: begin
                           if (!good) begin
                              bad = 1'b1;
                           end else begin
                              cmd.left_dec = 1'b1;
                              if (sts.left_is_one) begin
                                 ok_in     = 1'b1;
                                 active_in = 1'b0;
                                 await_in  = drs_pkg::EV_NONE;
                                 err_in    = '0;
                                 state_in  = drs_pkg::S_OUT_DONE;
                              end else begin
                                 cmd.sector_inc = 1'b1;
                                 done_next_in   = 1'b0;
                                 state_in       = drs_pkg::S_OUT_XFER;
                              end
                           end
                        end
                        drs_pkg::EV_RECAL: begin
                           if (!good) begin
                              bad = 1'b1;
                           end else begin
                              await_in = drs_pkg::EV_NONE;
                              state_in = drs_pkg::S_MUL_A;
                           end
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase

               // error path: count, mark reset, fail or dispatch again
               if (bad) begin
                  if (err_inc > drs_pkg::RESET_LIMIT) rst_pend_in = 1'b1;
                  await_in = drs_pkg::EV_NONE;
                  if (err_inc >= drs_pkg::MAX_RETRIES) begin
                     active_in = 1'b0;
                     err_in    = '0;
                     ok_in     = 1'b0;
                     state_in  = drs_pkg::S_OUT_DONE;
                  end else begin
                     err_in   = err_inc;
                     state_in = drs_pkg::S_MUL_A;
                  end
               end
            end
         end
         drs_pkg::S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = drs_pkg::S_MUL_B;
         end
         drs_pkg::S_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = drs_pkg::S_CHECK;
         end
         drs_pkg::S_CHECK: begin
            if (!sts.bounds_ok) begin
               active_in = 1'b0;
               err_in    = '0;
               ok_in     = 1'b0;
               await_in  = drs_pkg::EV_NONE;
               state_in  = drs_pkg::S_OUT_DONE;
            end else if (rst_pend_ff) begin
               rst_pend_in = 1'b0;
               recal_in    = 1'b1;
               await_in    = drs_pkg::EV_RECAL;
               state_in    = drs_pkg::S_OUT_RESET;
            end else if (recal_ff) begin
               recal_in = 1'b0;
               await_in = drs_pkg::EV_RECAL;
               state_in = drs_pkg::S_OUT_RESTORE;
            end else begin
               cmd.div_sec = 1'b1;
               await_in    = write_ff ? drs_pkg::EV_DRQ : drs_pkg::EV_READ;
               state_in    = drs_pkg::S_DIV_SEC;
            end
         end
         drs_pkg::S_DIV_SEC: begin
            if (!sts.div_busy) begin
               cmd.div_head = 1'b1;
               state_in     = drs_pkg::S_DIV_HEAD;
            end
         end
         drs_pkg::S_DIV_HEAD: begin
            if (!sts.div_busy) state_in = drs_pkg::S_OUT_COMMAND;
         end
         drs_pkg::S_OUT_RESET: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = drs_pkg::KIND_RESET;
               state_in      = drs_pkg::S_OUT_SPECIFY;
            end
         end
         drs_pkg::S_OUT_SPECIFY: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = drs_pkg::KIND_CMD;
               cmd.emit_cmd  = drs_pkg::CMD_SPECIFY;
               cmd.emit_last = 1'b1;
               state_in      = drs_pkg::S_IDLE;
            end
         end
         drs_pkg::S_OUT_RESTORE: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = drs_pkg::KIND_CMD;
               cmd.emit_cmd  = drs_pkg::CMD_RESTORE;
               cmd.emit_last = 1'b1;
               state_in      = drs_pkg::S_IDLE;
            end
         end
         drs_pkg::S_OUT_COMMAND: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = drs_pkg::KIND_CMD;
               cmd.emit_cmd  = write_ff ? drs_pkg::CMD_WRITE : drs_pkg::CMD_READ;
               cmd.emit_last = 1'b1;
               state_in      = drs_pkg::S_IDLE;
            end
         end
         drs_pkg::S_OUT_XFER: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = drs_pkg::KIND_XFER;
               cmd.emit_last = !done_next_ff;
               state_in      = done_next_ff ? drs_pkg::S_OUT_DONE : drs_pkg::S_IDLE;
            end
         end
         drs_pkg::S_OUT_DONE: begin
            if (sts.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_kind    = drs_pkg::KIND_DONE;
               cmd.emit_success = ok_ff;
               cmd.emit_last    = 1'b1;
               state_in         = drs_pkg::S_IDLE;
            end
         end
         default: state_in = drs_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/disk_request_sequencer_top.sv
// Disk request sequencer for a two-drive CHS disk controller. Each input
// transaction (submit, completion interrupt or data-ready poll) is taken only
// while the sequencer is idle and yields zero, one or two result transactions.
// An interrupt or poll that needs no new command goes straight to its result
// states. A submit, or any event that dispatches a command, first runs the
// capacity check; a read or write then takes two 32-step divisions (sector
// by sectors per track, track by heads) in one shared bit-serial divider.
// Write geometry through the csr port only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
`include "disk_request_sequencer_top_macros.svh"
module disk_request_sequencer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // minor_device, start_sector, sector_total, is_write, status_byte, data_ready
   input  wire logic [55:0] req_tdata,
   // op
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // command, drive, sector_number, head, cylinder, count_field, success
   output logic [39:0]      rsp_tdata,
   // kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   drs_pkg::ctrl_cmd_type  cmd_s;
   drs_pkg::dp_status_type sts_s;
   logic [1:0]  rsp_command;
   logic        rsp_drive;
   logic [7:0]  rsp_sector_number;
   logic [3:0]  rsp_head;
   logic [15:0] rsp_cylinder;
   logic [7:0]  rsp_count_field;
   logic        rsp_success;

   drs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .op          (req_tuser),
      .is_write    (req_tdata[44]),
      .status_byte (req_tdata[52:45]),
      .data_ready  (req_tdata[53]),
      .sts         (sts_s),
      .cmd         (cmd_s)
   );

   drs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .minor_device      (req_tdata[3:0]),
      .start_sector      (req_tdata[35:4]),
      .sector_total      (req_tdata[43:36]),
      .cmd               (cmd_s),
      .sts               (sts_s),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_kind          (rsp_tuser),
      .rsp_command       (rsp_command),
      .rsp_drive         (rsp_drive),
      .rsp_sector_number (rsp_sector_number),
      .rsp_head          (rsp_head),
      .rsp_cylinder      (rsp_cylinder),
      .rsp_count_field   (rsp_count_field),
      .rsp_success       (rsp_success),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {rsp_success, rsp_count_field, rsp_cylinder, rsp_head,
                       rsp_sector_number, rsp_drive, rsp_command};

   // a new result never overwrites one that is still waiting
   `DRS_ASSERT_SAME(a_emit_free, cmd_s.emit, sts_s.out_free)
   // the divider is only started when idle
   `DRS_ASSERT_SAME(a_div_idle, cmd_s.div_sec || cmd_s.div_head, !sts_s.div_busy)
   // a started division keeps the divider busy in the next cycle
   `DRS_ASSERT_NEXT(a_div_run, cmd_s.div_sec, sts_s.div_busy)

endmodule
`default_nettype wire
